@@ sv/rar_pkg.sv @@
// ---------------------------------------------------------------------------
// rar_pkg
// Types and constants shared by the rational arithmetic reduce block.
// ---------------------------------------------------------------------------
package rar_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int NUM_WIDTH     = 33;
   localparam int DEN_WIDTH     = 31;
   localparam int CNT_WIDTH     = $clog2(PROD_WIDTH);
   localparam int SHIFT_WIDTH   = $clog2(PROD_WIDTH);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                           command;
      logic signed [OPERAND_WIDTH-1:0]   left_numerator;
      logic signed [OPERAND_WIDTH-1:0]   left_denominator;
      logic signed [OPERAND_WIDTH-1:0]   right_numerator;
      logic signed [OPERAND_WIDTH-1:0]   right_denominator;
   } req_type;

   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] result_numerator;
      logic [DEN_WIDTH-1:0]        result_denominator;
      logic                        zero_denominator;
   } rsp_type;

   typedef struct packed {
      logic                  zero;
      logic                  neg;
      logic [PROD_WIDTH-1:0] num_mag;
      logic [PROD_WIDTH-1:0] den_mag;
   } frac_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_GCD,
      B_DIV
   } back_state_type;

endpackage

@@ sv/rational_arith_reduce_top.sv @@
// Path: from accept a word passes through the front multiplier and the queue into the
// back; a zero denominator is answered from there directly, otherwise the binary GCD
// loop and 32 divide steps follow before the result is registered.
// Throughput: one word per back pass, set by the binary GCD loop and the
// 32-step restoring dividers; the front runs ahead into a two-entry queue.
// Reset: synchronous, active high; clears all control state and empties the queue.
// ---------------------------------------------------------------------------
// rational_arith_reduce_top
// Fraction add, subtract, multiply and divide with reduction to lowest terms.
// ---------------------------------------------------------------------------
module rational_arith_reduce_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rar_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rar_pkg::rsp_type rsp_word
);
   import rar_pkg::*;

   frac_type push_word, pop_word;
   logic push_valid, push_ready, pop_valid, pop_ready;

   rar_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .push_valid(push_valid), .push_ready(push_ready), .push_word(push_word)
   );

   rar_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_word(push_word),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_word(pop_word)
   );

   rar_back u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_word(pop_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

endmodule

@@ sv/rar_front.sv @@
// ---------------------------------------------------------------------------
// rar_front
// Accepts a word, forms the cross products on one shared multiplier and
// pushes the signed fraction into the queue.
// ---------------------------------------------------------------------------
module rar_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rar_pkg::req_type  req_word,
   output logic              push_valid,
   input  logic              push_ready,
   output rar_pkg::frac_type push_word
);
   import rar_pkg::*;

   front_state_type state_ff, state_in;
   logic [1:0] step_ff, step_in;
   req_type req_ff;
   logic signed [PROD_WIDTH-1:0] pa_ff, pb_ff, pd_ff;
   logic signed [OPERAND_WIDTH-1:0] mx, my;
   logic signed [PROD_WIDTH-1:0] prod;
   logic signed [PROD_WIDTH:0] num;
   logic signed [PROD_WIDTH-1:0] den;
   logic [PROD_WIDTH:0] num_abs;
   logic [PROD_WIDTH-1:0] den_abs;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (req_valid) state_in = F_MUL;
         F_MUL:  if (step_ff == 2'd2) state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE:  req_ready  = 1'b1;
         F_PUSH:  push_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      case (step_ff)
         2'd0: begin
            mx = req_ff.left_numerator;
            my = (req_ff.command == CMD_MUL) ? req_ff.right_numerator
                                             : req_ff.right_denominator;
         end
         2'd1: begin
            mx = req_ff.left_denominator;
            my = req_ff.right_numerator;
         end
         default: begin
            mx = req_ff.left_denominator;
            my = req_ff.right_denominator;
         end
      endcase
      prod = PROD_WIDTH'(mx) * PROD_WIDTH'(my);
   end

   assign step_in = (state_ff == F_MUL) ? step_ff + 2'd1 : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      if (req_valid && req_ready) req_ff <= req_word;
      if (state_ff == F_MUL) begin
         case (step_ff)
            2'd0:    pa_ff <= prod;
            2'd1:    pb_ff <= prod;
            default: pd_ff <= prod;
         endcase
      end
   end

   always_comb begin
      case (req_ff.command)
         CMD_ADD: num = {pa_ff[PROD_WIDTH-1], pa_ff} + {pb_ff[PROD_WIDTH-1], pb_ff};
         CMD_SUB: num = {pa_ff[PROD_WIDTH-1], pa_ff} - {pb_ff[PROD_WIDTH-1], pb_ff};
         default: num = {pa_ff[PROD_WIDTH-1], pa_ff};
      endcase
      den     = (req_ff.command == CMD_DIV) ? pb_ff : pd_ff;
      num_abs = num[PROD_WIDTH] ? -num : num;
      den_abs = den[PROD_WIDTH-1] ? -den : den;
      push_word.zero    = (den == '0);
      push_word.neg     = num[PROD_WIDTH] ^ den[PROD_WIDTH-1];
      push_word.num_mag = num_abs[PROD_WIDTH-1:0];
      push_word.den_mag = den_abs;
   end

endmodule

@@ sv/rar_queue.sv @@
// ---------------------------------------------------------------------------
// rar_queue
// Two-entry queue of fractions between the front and the back.
// ---------------------------------------------------------------------------
module rar_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rar_pkg::frac_type push_word,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rar_pkg::frac_type pop_word
);
   import rar_pkg::*;

   frac_type mem_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_word   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) mem_ff[wr_ff] <= push_word;
   end

endmodule

@@ sv/rar_back.sv @@
// ---------------------------------------------------------------------------
// rar_back
// Reduces a fraction: binary GCD loop, then two restoring dividers in step,
// result held in an output register.
// ---------------------------------------------------------------------------
module rar_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rar_pkg::frac_type pop_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rar_pkg::rsp_type  rsp_word
);
   import rar_pkg::*;

   back_state_type state_ff, state_in;
   logic [PROD_WIDTH-1:0] u_ff, v_ff, u_in, v_in, g_ff;
   logic [SHIFT_WIDTH-1:0] k_ff, k_in;
   logic [PROD_WIDTH-1:0] nq_ff, dq_ff, nq_in, dq_in;
   logic [PROD_WIDTH-1:0] nr_ff, dr_ff, nr_in, dr_in;
   logic [PROD_WIDTH:0] nt, dt;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic neg_ff, rsp_valid_ff;
   rsp_type rsp_ff;
   logic [NUM_WIDTH-1:0] nmag;
   logic take, load_zero, load_div, gcd_done, div_done;

   assign gcd_done = (u_ff == '0);
   assign div_done = (cnt_ff == CNT_WIDTH'(PROD_WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (pop_valid && !rsp_valid_ff && !pop_word.zero) state_in = B_GCD;
         B_GCD:  if (gcd_done) state_in = B_DIV;
         B_DIV:  if (div_done) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      load_div  = 1'b0;
      unique case (state_ff)
         B_IDLE:  pop_ready = !rsp_valid_ff;
         B_DIV:   load_div  = div_done;
         default: ;
      endcase
      take      = pop_valid && pop_ready;
      load_zero = take && pop_word.zero;
   end

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = u_ff - v_ff;
      end else begin
         v_in = v_ff - u_ff;
      end
   end

   always_comb begin
      nt = {nr_ff, nq_ff[PROD_WIDTH-1]};
      dt = {dr_ff, dq_ff[PROD_WIDTH-1]};
      nr_in = nt[PROD_WIDTH-1:0];
      dr_in = dt[PROD_WIDTH-1:0];
      nq_in = {nq_ff[PROD_WIDTH-2:0], 1'b0};
      dq_in = {dq_ff[PROD_WIDTH-2:0], 1'b0};
      if (nt >= {1'b0, g_ff}) begin
         nr_in    = PROD_WIDTH'(nt - {1'b0, g_ff});
         nq_in[0] = 1'b1;
      end
      if (dt >= {1'b0, g_ff}) begin
         dr_in    = PROD_WIDTH'(dt - {1'b0, g_ff});
         dq_in[0] = 1'b1;
      end
      nmag = NUM_WIDTH'(nq_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_zero || load_div) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         u_ff   <= pop_word.num_mag;
         v_ff   <= pop_word.den_mag;
         k_ff   <= '0;
         nq_ff  <= pop_word.num_mag;
         dq_ff  <= pop_word.den_mag;
         neg_ff <= pop_word.neg;
      end
      if (state_ff == B_GCD) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
         g_ff   <= v_ff << k_ff;
         nr_ff  <= '0;
         dr_ff  <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == B_DIV) begin
         nq_ff  <= nq_in;
         dq_ff  <= dq_in;
         nr_ff  <= nr_in;
         dr_ff  <= dr_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (load_zero) begin
         rsp_ff.result_numerator   <= '0;
         rsp_ff.result_denominator <= '0;
         rsp_ff.zero_denominator   <= 1'b1;
      end else if (load_div) begin
         rsp_ff.result_numerator   <= (neg_ff && nmag != '0) ? -nmag : nmag;
         rsp_ff.result_denominator <= dq_in[DEN_WIDTH-1:0];
         rsp_ff.zero_denominator   <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
